>>> sv/quaternion_nlerp_to_matrix_macros.svh
// Assertion macros for the quaternion nlerp to matrix block.
// Used by the checker; expects clk and arst_n in scope.
`ifndef QUATERNION_NLERP_TO_MATRIX_MACROS_SVH
`define QUATERNION_NLERP_TO_MATRIX_MACROS_SVH

// plain property, off during reset
`define QNM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication, off during reset
`define QNM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/qnm_pkg.sv
// Shared types and constants for the quaternion nlerp to matrix block.
// No dependencies.
`default_nettype none
package qnm_pkg;
	localparam int CB = 16;                 // component width
	localparam int FB = CB - 2;             // fraction bits of a component
	localparam int FRW = 17;                // fraction port width
	localparam logic [FRW-1:0] FR_ONE = FRW'(65536);
	localparam int DIFW = CB + 2;           // target minus first
	localparam int TW = CB + 20;            // fraction times difference
	localparam int CW = CB + 2;             // blended component
	localparam int MW = CB + 2;             // blended magnitude
	localparam int PW = $clog2(MW);         // leading one position
	localparam int NW = 2 * CB;             // squared norm
	localparam int NUMW = 2 * CB + 2;       // entry numerator
	localparam int DW = 2 * CB + FB + 1;    // divider dividend
	localparam int QB = CB - 1;             // quotient bits
	localparam int LATENCY = QB + 12;       // start to done, in cycles

	typedef struct packed {
		logic signed [CB-1:0] from_w;
		logic signed [CB-1:0] from_x;
		logic signed [CB-1:0] from_y;
		logic signed [CB-1:0] from_z;
		logic signed [CB-1:0] to_w;
		logic signed [CB-1:0] to_x;
		logic signed [CB-1:0] to_y;
		logic signed [CB-1:0] to_z;
		logic [FRW-1:0] fraction;
		logic interpolate;
	} qnm_req_t;

	typedef struct packed {
		logic signed [CB-1:0] m00;
		logic signed [CB-1:0] m01;
		logic signed [CB-1:0] m02;
		logic signed [CB-1:0] m10;
		logic signed [CB-1:0] m11;
		logic signed [CB-1:0] m12;
		logic signed [CB-1:0] m20;
		logic signed [CB-1:0] m21;
		logic signed [CB-1:0] m22;
	} qnm_res_t;
endpackage
`default_nettype wire

>>> sv/qnm_div.sv
// Pipelined restoring divider, nine lanes sharing one divisor, one
// quotient bit per stage. Depends on qnm_pkg.
`default_nettype none
module qnm_div import qnm_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            vld,
	input  wire logic [NW-1:0]   dvs,
	input  wire logic [DW-1:0]   dvd [9],
	input  wire logic [8:0]      sgn,
	output logic                 quo_vld,
	output logic [QB-1:0]        quo [9],
	output logic [8:0]           quo_sgn
);
	logic [DW-1:0] rem_s [QB][9];
	logic [QB-1:0] q_s [QB][9];
	logic [NW-1:0] n_s [QB];
	logic [8:0]    sg_s [QB];
	logic [QB-1:0] v_s;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int B = QB - 1 - k;
		logic [DW-1:0] rem_i [9];
		logic [QB-1:0] q_i [9];
		logic [NW-1:0] n_i;
		logic [8:0]    sg_i;
		logic          v_i;
		logic [DW-1:0] sub;

		if (k == 0) begin : g_first
			assign rem_i = dvd;
			assign n_i = dvs;
			assign sg_i = sgn;
			assign v_i = vld;
			for (genvar j = 0; j < 9; j++) begin : g_z
				assign q_i[j] = '0;
			end
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign q_i = q_s[k-1];
			assign n_i = n_s[k-1];
			assign sg_i = sg_s[k-1];
			assign v_i = v_s[k-1];
		end

		assign sub = DW'(n_i) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			n_s[k] <= n_i;
			sg_s[k] <= sg_i;
			for (int j = 0; j < 9; j++) begin
				if (rem_i[j] >= sub) begin
					rem_s[k][j] <= rem_i[j] - sub;
					q_s[k][j] <= {q_i[j][QB-2:0], 1'b1};
				end else begin
					rem_s[k][j] <= rem_i[j];
					q_s[k][j] <= {q_i[j][QB-2:0], 1'b0};
				end
			end
		end
	end

	assign quo_vld = v_s[QB-1];
	assign quo = q_s[QB-1];
	assign quo_sgn = sg_s[QB-1];
endmodule
`default_nettype wire

>>> sv/quaternion_nlerp_to_matrix.sv
// Top level: quaternion nlerp followed by conversion to a 3x3 rotation matrix.
// Depends on qnm_pkg and qnm_div.
`default_nettype none
// One item enters per cycle whenever start is high; busy is always low since
// the receiver cannot stall and the pipeline never holds. Each item comes out
// as a one-cycle done strobe with the nine entries.
// The depth is eleven front stages (dot sign, blend multiply, max and
// normalizing shift, ten products, numerator sums, dividend setup), fifteen
// divider stages that retire one quotient bit each, and the output register.
// Items stay in order; there is no other state, so nothing is cleared after
// reset beyond the valid bits.
module quaternion_nlerp_to_matrix import qnm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire qnm_req_t request,
	output logic          busy,
	output logic          done,
	output qnm_res_t      result
);
	logic [10:0] vld_q;   // valid of stages 1..11

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[9:0], start & ~busy};
		end
	end

	// stage 1: products for the dot sign, fraction clamp
	logic signed [CB-1:0] a_in [4];
	logic signed [CB-1:0] b_in [4];
	logic signed [CB-1:0] a_s1 [4];
	logic signed [CB-1:0] b_s1 [4];
	logic signed [NW-1:0] p_s1 [4];
	logic [FRW-1:0] fr_s1;
	logic ip_s1;

	assign a_in[0] = request.from_w;
	assign a_in[1] = request.from_x;
	assign a_in[2] = request.from_y;
	assign a_in[3] = request.from_z;
	assign b_in[0] = request.to_w;
	assign b_in[1] = request.to_x;
	assign b_in[2] = request.to_y;
	assign b_in[3] = request.to_z;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			a_s1[i] <= a_in[i];
			b_s1[i] <= b_in[i];
			p_s1[i] <= a_in[i] * b_in[i];
		end
		fr_s1 <= (request.fraction > FR_ONE) ? FR_ONE : request.fraction;
		ip_s1 <= request.interpolate;
	end

	// stage 2: exact dot product, take its sign
	logic signed [NW+1:0] dot;
	logic signed [CB-1:0] a_s2 [4];
	logic signed [CB-1:0] b_s2 [4];
	logic [FRW-1:0] fr_s2;
	logic ip_s2, neg_s2;

	assign dot = (NW+2)'(p_s1[0]) + (NW+2)'(p_s1[1]) + (NW+2)'(p_s1[2])
		+ (NW+2)'(p_s1[3]);

	always_ff @(posedge clk) begin
		a_s2 <= a_s1;
		b_s2 <= b_s1;
		fr_s2 <= fr_s1;
		ip_s2 <= ip_s1;
		neg_s2 <= dot < 0;
	end

	// stage 3: shortest-arc target minus first
	logic signed [CB-1:0] a_s3 [4];
	logic signed [DIFW-1:0] d_s3 [4];
	logic [FRW-1:0] fr_s3;
	logic ip_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			d_s3[i] <= (neg_s2 ? -DIFW'(b_s2[i]) : DIFW'(b_s2[i])) - DIFW'(a_s2[i]);
		end
		a_s3 <= a_s2;
		fr_s3 <= fr_s2;
		ip_s3 <= ip_s2;
	end

	// stage 4: fraction times difference
	logic signed [CB-1:0] a_s4 [4];
	logic signed [TW-1:0] t_s4 [4];
	logic ip_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			t_s4[i] <= $signed({1'b0, fr_s3}) * d_s3[i];
		end
		a_s4 <= a_s3;
		ip_s4 <= ip_s3;
	end

	// stage 5: round the step (floor of t + half), add to first
	logic signed [TW-1:0] rs [4];
	logic signed [CW-1:0] c_s5 [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rs[i] = (t_s4[i] + TW'(32768)) >>> 16;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			c_s5[i] <= ip_s4 ? CW'(a_s4[i]) + $signed(rs[i][CW-1:0]) : CW'(a_s4[i]);
		end
	end

	// stage 6: largest magnitude
	logic [MW-1:0] mag5 [4];
	logic [MW-1:0] mx01, mx23;
	logic [MW-1:0] mx_s6;
	logic signed [CW-1:0] c_s6 [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag5[i] = c_s5[i] < 0 ? MW'(-c_s5[i]) : MW'(c_s5[i]);
		end
		mx01 = mag5[0] > mag5[1] ? mag5[0] : mag5[1];
		mx23 = mag5[2] > mag5[3] ? mag5[2] : mag5[3];
	end

	always_ff @(posedge clk) begin
		mx_s6 <= mx01 > mx23 ? mx01 : mx23;
		c_s6 <= c_s5;
	end

	// stage 7: leading one, shift so the largest lands in [2^FB, 2^(FB+1))
	logic [PW-1:0] lead;
	logic [PW-1:0] rsh_s7, lsh_s7;
	logic zero_s7;
	logic signed [CW-1:0] c_s7 [4];

	always_comb begin
		lead = '0;
		for (int i = 0; i < MW; i++) begin
			if (mx_s6[i]) lead = PW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (lead > PW'(FB)) begin
			rsh_s7 <= lead - PW'(FB);
			lsh_s7 <= '0;
		end else begin
			rsh_s7 <= '0;
			lsh_s7 <= PW'(FB) - lead;
		end
		zero_s7 <= mx_s6 == '0;
		c_s7 <= c_s6;
	end

	// stage 8: scaled components, magnitude truncated, sign kept
	logic [MW-1:0] mag7 [4];
	logic [MW-1:0] qm [4];
	logic signed [CB-1:0] q_s8 [4];
	logic zero_s8;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag7[i] = c_s7[i] < 0 ? MW'(-c_s7[i]) : MW'(c_s7[i]);
			qm[i] = (mag7[i] >> rsh_s7) << lsh_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			q_s8[i] <= c_s7[i] < 0 ? -$signed(qm[i][CB-1:0]) : $signed(qm[i][CB-1:0]);
		end
		zero_s8 <= zero_s7;
	end

	// stage 9: the ten products; q index 0..3 is w x y z
	logic signed [NW-1:0] sq_s9 [4];
	logic signed [NW-1:0] xy_s9, wz_s9, xz_s9, wy_s9, yz_s9, wx_s9;
	logic zero_s9;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			sq_s9[i] <= q_s8[i] * q_s8[i];
		end
		xy_s9 <= q_s8[1] * q_s8[2];
		wz_s9 <= q_s8[0] * q_s8[3];
		xz_s9 <= q_s8[1] * q_s8[3];
		wy_s9 <= q_s8[0] * q_s8[2];
		yz_s9 <= q_s8[2] * q_s8[3];
		wx_s9 <= q_s8[0] * q_s8[1];
		zero_s9 <= zero_s8;
	end

	// stage 10: norm and numerators; a zero quaternion becomes n = 1 with
	// unit diagonal numerators, so the divider yields the identity
	logic signed [NUMW-1:0] ww, xx, yy, zz, nsum;
	logic signed [NUMW-1:0] num [9];
	logic [NW-1:0] n_s10;
	logic signed [NUMW-1:0] num_s10 [9];

	always_comb begin
		ww = NUMW'(sq_s9[0]);
		xx = NUMW'(sq_s9[1]);
		yy = NUMW'(sq_s9[2]);
		zz = NUMW'(sq_s9[3]);
		nsum = ww + xx + yy + zz;
		num[0] = ww + xx - yy - zz;
		num[1] = (NUMW'(xy_s9) + NUMW'(wz_s9)) <<< 1;
		num[2] = (NUMW'(xz_s9) - NUMW'(wy_s9)) <<< 1;
		num[3] = (NUMW'(xy_s9) - NUMW'(wz_s9)) <<< 1;
		num[4] = ww - xx + yy - zz;
		num[5] = (NUMW'(yz_s9) + NUMW'(wx_s9)) <<< 1;
		num[6] = (NUMW'(xz_s9) + NUMW'(wy_s9)) <<< 1;
		num[7] = (NUMW'(yz_s9) - NUMW'(wx_s9)) <<< 1;
		num[8] = ww - xx - yy + zz;
	end

	always_ff @(posedge clk) begin
		if (zero_s9) begin
			n_s10 <= NW'(1);
			for (int j = 0; j < 9; j++) begin
				num_s10[j] <= (j == 0 || j == 4 || j == 8) ? NUMW'(1) : '0;
			end
		end else begin
			n_s10 <= nsum[NW-1:0];
			num_s10 <= num;
		end
	end

	// stage 11: dividend = |num| * 2^FB + n/2, for round half away from zero
	logic [NUMW-1:0] anum [9];
	logic [DW-1:0] dvd_s11 [9];
	logic [8:0] sg_s11;
	logic [NW-1:0] n_s11;

	always_comb begin
		for (int j = 0; j < 9; j++) begin
			anum[j] = num_s10[j] < 0 ? NUMW'(-num_s10[j]) : NUMW'(num_s10[j]);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 9; j++) begin
			dvd_s11[j] <= (DW'(anum[j]) << FB) + DW'(n_s10 >> 1);
			sg_s11[j] <= num_s10[j] < 0;
		end
		n_s11 <= n_s10;
	end

	// divider: |num| <= n, so the quotient never exceeds 2^FB
	logic div_vld;
	logic [QB-1:0] quo [9];
	logic [8:0] quo_sgn;

	qnm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld_q[10]),
		.dvs     (n_s11),
		.dvd     (dvd_s11),
		.sgn     (sg_s11),
		.quo_vld (div_vld),
		.quo     (quo),
		.quo_sgn (quo_sgn)
	);

	// output register
	logic done_q;
	logic signed [CB-1:0] m_q [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 9; j++) begin
			m_q[j] <= quo_sgn[j] ? -$signed({1'b0, quo[j]}) : $signed({1'b0, quo[j]});
		end
	end

	assign done = done_q;
	assign result.m00 = m_q[0];
	assign result.m01 = m_q[1];
	assign result.m02 = m_q[2];
	assign result.m10 = m_q[3];
	assign result.m11 = m_q[4];
	assign result.m12 = m_q[5];
	assign result.m20 = m_q[6];
	assign result.m21 = m_q[7];
	assign result.m22 = m_q[8];
endmodule
`default_nettype wire

>>> sv/qnm_chk.sv
// Port-level checker for quaternion_nlerp_to_matrix, bound to the top level.
// Depends on qnm_pkg and the assertion macro header.
`default_nettype none
`include "quaternion_nlerp_to_matrix_macros.svh"
module qnm_chk import qnm_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire qnm_req_t request,
	input wire logic     busy,
	input wire logic     done,
	input wire qnm_res_t result
);
	localparam int AW = $clog2(LATENCY + 2);
	localparam logic signed [CB-1:0] ONE = CB'(1 << FB);

	logic [AW-1:0] age_q;   // cycles since reset, saturating
	logic warm;
	logic id_in;
	logic id_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q <= AW'(LATENCY)) begin
			age_q <= age_q + 1'b1;
		end
	end

	assign warm = age_q > AW'(LATENCY);
	assign id_in = start && !busy && !request.interpolate && request.from_w == '0
		&& request.from_x == '0 && request.from_y == '0 && request.from_z == '0;
	assign id_out = result.m00 == ONE && result.m11 == ONE && result.m22 == ONE
		&& result.m01 == '0 && result.m02 == '0 && result.m10 == '0
		&& result.m12 == '0 && result.m20 == '0 && result.m21 == '0;

	`QNM_ASSERT(a_never_busy, !busy, "busy raised")
	`QNM_ASSERT_IMP(a_latency, warm, done == $past(start && !busy, LATENCY), "done out of step")
	`QNM_ASSERT_IMP(a_identity, warm && $past(id_in, LATENCY), done && id_out, "zero not identity")
endmodule

bind quaternion_nlerp_to_matrix qnm_chk u_qnm_chk (.*);
`default_nettype wire

>>> sim/qnm_checker.sv
// Checker for the quaternion nlerp to matrix block: predicts each matrix
// from the accepted items and compares it with every done strobe. Uses qnm_pkg.
`timescale 1ns / 1ps
module qnm_checker import qnm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     busy,
	input  wire qnm_req_t request,
	input  wire logic     done,
	input  wire qnm_res_t result,
	output int            fail_count,
	output int            pending
);
	qnm_res_t matrix_q[$];

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	// num * 2^FB / n, half away from zero, saturated
	function automatic logic [CB-1:0] ratio_entry(longint num, longint n);
		longint mag, q, lim;
		mag = num < 0 ? -num : num;
		q = ((mag <<< FB) + n / 2) / n;
		lim = num < 0 ? (longint'(1) <<< (CB-1)) : (longint'(1) <<< (CB-1)) - 1;
		if (q > lim) q = lim;
		return CB'(num < 0 ? -q : q);
	endfunction

	function automatic qnm_res_t predict_matrix(qnm_req_t r);
		longint a[4], b[4], c[4], q[4], mag[4];
		longint mx, fr, dot, w, x, y, z, n;
		int rs, ls;
		qnm_res_t m;
		a[0] = r.from_w; a[1] = r.from_x; a[2] = r.from_y; a[3] = r.from_z;
		b[0] = r.to_w; b[1] = r.to_x; b[2] = r.to_y; b[3] = r.to_z;
		for (int i = 0; i < 4; i++) c[i] = a[i];
		if (r.interpolate) begin
			fr = r.fraction > FR_ONE ? 65536 : longint'(r.fraction);
			dot = 0;
			for (int i = 0; i < 4; i++) dot += a[i] * b[i];
			for (int i = 0; i < 4; i++) begin
				if (dot < 0) b[i] = -b[i];
				c[i] = a[i] + floor_shr(fr * (b[i] - a[i]) + 32768, 16);
			end
		end
		mx = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = c[i] < 0 ? -c[i] : c[i];
			if (mag[i] > mx) mx = mag[i];
		end
		if (mx == 0) begin
			m = '0;
			m.m00 = CB'(1 << FB); m.m11 = CB'(1 << FB); m.m22 = CB'(1 << FB);
			return m;
		end
		rs = 0; ls = 0;
		while (mx >= 32768) begin mx >>= 1; rs++; end
		while (mx < 16384) begin mx <<= 1; ls++; end
		for (int i = 0; i < 4; i++) begin
			q[i] = (mag[i] >> rs) << ls;
			if (c[i] < 0) q[i] = -q[i];
		end
		w = q[0]; x = q[1]; y = q[2]; z = q[3];
		n = w*w + x*x + y*y + z*z;
		m.m00 = ratio_entry(w*w + x*x - y*y - z*z, n);
		m.m01 = ratio_entry(2*(x*y + w*z), n);
		m.m02 = ratio_entry(2*(x*z - w*y), n);
		m.m10 = ratio_entry(2*(x*y - w*z), n);
		m.m11 = ratio_entry(w*w - x*x + y*y - z*z, n);
		m.m12 = ratio_entry(2*(y*z + w*x), n);
		m.m20 = ratio_entry(2*(x*z + w*y), n);
		m.m21 = ratio_entry(2*(y*z - w*x), n);
		m.m22 = ratio_entry(w*w - x*x - y*y + z*z, n);
		return m;
	endfunction

	task automatic cmp(string name, logic [CB-1:0] e, logic [CB-1:0] a);
		if (e !== a) begin
			$error("%s: expected %0d actual %0d", name, $signed(e), $signed(a));
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		qnm_res_t e;
		if (arst_n) begin
			if (done) begin
				if (matrix_q.size() == 0) begin
					$error("unexpected matrix on done");
					fail_count++;
				end else begin
					e = matrix_q.pop_front();
					cmp("m00", e.m00, result.m00); cmp("m01", e.m01, result.m01);
					cmp("m02", e.m02, result.m02); cmp("m10", e.m10, result.m10);
					cmp("m11", e.m11, result.m11); cmp("m12", e.m12, result.m12);
					cmp("m20", e.m20, result.m20); cmp("m21", e.m21, result.m21);
					cmp("m22", e.m22, result.m22);
				end
			end
			if (start && !busy) matrix_q.push_back(predict_matrix(request));
			pending = matrix_q.size();
		end
	end
endmodule

>>> sim/testbench.sv
// Top of the quaternion nlerp to matrix testbench: clock, reset, stimulus
// and verdict. Depends on qnm_pkg, qnm_checker and the block itself.
`timescale 1ns / 1ps
module testbench;
	import qnm_pkg::*;

	localparam int WATCHDOG = 2000;

	logic     clk;
	logic     arst_n;
	logic     start;
	qnm_req_t request;
	logic     busy;
	logic     done;
	qnm_res_t result;
	int       fail_count;
	int       pending;
	int       idle_cycles;

	quaternion_nlerp_to_matrix i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request),
		.busy(busy), .done(done), .result(result)
	);

	qnm_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog: counts cycles with no item in and no matrix out
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	// component biased toward extremes, zero and unit values
	function automatic logic [CB-1:0] pick_comp();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'sh4000;
			4: return 16'shc000;
			5: return CB'(int'($urandom_range(0, 15)) - 8);
			default: return CB'($urandom);
		endcase
	endfunction

	function automatic qnm_req_t rand_item();
		qnm_req_t r;
		r.from_w = pick_comp(); r.from_x = pick_comp();
		r.from_y = pick_comp(); r.from_z = pick_comp();
		r.to_w = pick_comp(); r.to_x = pick_comp();
		r.to_y = pick_comp(); r.to_z = pick_comp();
		case ($urandom_range(0, 5))
			0: r.fraction = '0;
			1: r.fraction = FR_ONE;
			2: r.fraction = FRW'($urandom); // covers above one too
			default: r.fraction = FRW'($urandom_range(0, 65536));
		endcase
		r.interpolate = $urandom_range(0, 3) != 0;
		return r;
	endfunction

	// present one item at the falling edge and hold until accepted
	task automatic issue(qnm_req_t r);
		@(negedge clk);
		request <= r;
		start   <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic gap(int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	initial begin
		qnm_req_t r;
		int burst;
		start   = 1'b0;
		request = '0;
		arst_n  = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero quaternion, extremes, dot sign cases, fraction ends
		r = '0; issue(r);
		r.interpolate = 1'b1; issue(r);
		r = '0; r.from_w = 16'sh4000; issue(r);
		r = '0; r.from_w = 16'sh7fff; r.from_x = 16'sh7fff;
		r.from_y = 16'sh7fff; r.from_z = 16'sh7fff; issue(r);
		r = '0; r.from_w = 16'sh8000; r.from_x = 16'sh8000;
		r.from_y = 16'sh8000; r.from_z = 16'sh8000; issue(r);
		r = '0; r.from_x = 16'sh0001; issue(r);
		r = '0; r.from_w = 16'sh4000; r.to_w = 16'shc000;
		r.interpolate = 1'b1; r.fraction = 17'd32768; issue(r); // negative dot
		r.fraction = FR_ONE; issue(r);
		r.fraction = 17'h1ffff; issue(r);                     // above one
		r = '0; r.from_w = 16'sh4000; r.to_x = 16'sh4000;
		r.interpolate = 1'b1; r.fraction = 17'd32768; issue(r); // zero dot
		r.fraction = '0; issue(r);
		r = '0; r.from_w = 16'sh4000; r.to_w = 16'sh4000;
		r.interpolate = 1'b1; r.fraction = 17'd1; issue(r);
		r = '0; r.from_w = 16'sh0001; r.to_w = 16'shffff;
		r.interpolate = 1'b1; r.fraction = 17'd32768; issue(r); // negative dot, stays at w = 1
		r = '0; r.from_w = 16'sh7fff; r.to_w = 16'sh8000; r.to_z = 16'sh7fff;
		r.interpolate = 1'b1; r.fraction = 17'd49152; issue(r);
		r = '0; r.from_y = 16'sh8000; r.to_z = 16'sh8000;
		r.interpolate = 1'b0; r.fraction = FR_ONE; issue(r);

		// random bursts with gaps, some long back-to-back stretches
		for (int i = 0; i < 650; ) begin
			burst = $urandom_range(0, 7) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 8);
			for (int k = 0; k < burst; k++) begin
				issue(rand_item());
				i++;
			end
			gap($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : $urandom_range(0, 4));
		end
		@(negedge clk);
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
